// File: rtl/mono_page_framebuffer_draw_defines.svh
// Assertion macros shared by the frame store modules.
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPFB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpfb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpfb assertion failed");

`endif

// File: rtl/mpfb_pkg.sv
package mpfb_pkg;

  // Action codes carried on the action input.
  localparam logic [2:0] ACT_PIXEL = 3'd0;
  localparam logic [2:0] ACT_HLINE = 3'd1;
  localparam logic [2:0] ACT_VLINE = 3'd2;
  localparam logic [2:0] ACT_RECT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  // Memory operations.
  typedef enum logic [1:0] {
    MOP_RMW,
    MOP_FILL,
    MOP_READ
  } mem_op_t;

  // One memory access issued by the sequencer.
  typedef struct packed {
    logic       valid;
    mem_op_t    op;
    logic [7:0] mask;
    logic       lit;
  } mem_req_t;

  // Status of the sequencer toward the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic rd_sel;
  } ctrl_status_t;

  // Bit mask for rows row_lo..row_hi of one page; row r sits at bit 7-r.
  function automatic logic [7:0] page_mask(input logic [2:0] row_lo, input logic [2:0] row_hi);
    logic [7:0] m;
    m = 8'h00;
    for (int r = 0; r < 8; r++) begin
      m[7-r] = (3'(r) >= row_lo) && (3'(r) <= row_hi);
    end
    return m;
  endfunction

endpackage

// File: rtl/mpfb_store.sv
`include "mono_page_framebuffer_draw_defines.svh"

module mpfb_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mpfb_pkg::mem_req_t       req,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [7:0]               rdata
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_q;
  logic              s1_valid;
  mpfb_pkg::mem_op_t s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        s1_mask;
  logic              s1_lit;
  logic [7:0]        wdata;
  logic              wen;

  // Second stage tracks the access whose read data is now in rd_q.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op   <= req.op;
    s1_addr <= addr;
    s1_mask <= req.mask;
    s1_lit  <= req.lit;
  end

  // Modify step: set or clear the masked bits, or write a whole fill byte.
  always_comb begin
    wen = s1_valid && (s1_op == mpfb_pkg::MOP_RMW || s1_op == mpfb_pkg::MOP_FILL);
    case (s1_op)
      mpfb_pkg::MOP_FILL: wdata = {8{s1_lit}};
      mpfb_pkg::MOP_RMW:  wdata = s1_lit ? (rd_q | s1_mask) : (rd_q & ~s1_mask);
      default:            wdata = rd_q;
    endcase
  end

  // Frame store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[s1_addr] <= wdata;
    end
    if (req.valid) begin
      rd_q <= mem[addr];
    end
  end

  assign rdata = rd_q;

  // A read must never hit the entry whose write-back is in flight.
  `MPFB_ASSERT_IMPL(a_no_rmw_overlap, clk, rst, s1_valid && (s1_op == mpfb_pkg::MOP_RMW) && req.valid, addr != s1_addr)

endmodule

// File: rtl/mpfb_ctrl.sv
`include "mono_page_framebuffer_draw_defines.svh"

module mpfb_ctrl #(
  parameter int WIDTH      = 128,
  parameter int PAGE_COUNT = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [2:0]                                action,
  input  logic [6:0]                                x_start,
  input  logic [5:0]                                y_start,
  input  logic [6:0]                                x_end,
  input  logic [5:0]                                y_end,
  input  logic                                      color,
  input  logic [9:0]                                read_index,
  output mpfb_pkg::mem_req_t                        req,
  output logic [$clog2(WIDTH*PAGE_COUNT)-1:0]       req_addr,
  output mpfb_pkg::ctrl_status_t                    status
);

  localparam int DEPTH  = WIDTH * PAGE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = (ADDR_W > 10) ? ADDR_W : 10;
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] WIDTH_A     = ADDR_W'(WIDTH);
  localparam logic [8:0]        WIDTH_9     = 9'(WIDTH);
  localparam logic [4:0]        PAGES_5     = 5'(PAGE_COUNT);
  localparam logic [12:0]       DEPTH_13    = 13'(DEPTH);
  localparam logic [6:0]        X_LAST      = 7'(WIDTH - 1);
  localparam logic [2:0]        PAGE_LAST   = 3'(PAGE_COUNT - 1);

  mpfb_pkg::state_t  state;
  mpfb_pkg::state_t  state_next;
  logic              accept;

  logic [ADDR_W-1:0] sweep_addr;
  logic              rd_ok;
  logic [ADDR_W-1:0] read_addr;
  logic              lit;
  logic [6:0]        x_lo;
  logic [6:0]        x_hi;
  logic [6:0]        x_cur;
  logic [5:0]        y_lo;
  logic [5:0]        y_hi;
  logic [2:0]        page_cur;
  logic [2:0]        page_hi;
  logic [ADDR_W-1:0] base;

  logic              is_draw;
  logic [6:0]        dec_x_end;
  logic [6:0]        dec_x_hi;
  logic [5:0]        dec_y_hi;
  logic [2:0]        dec_page_hi;
  logic              dec_empty;
  logic              dec_rd_ok;
  logic [ADDR_W-1:0] dec_base;
  logic [SUM_W-1:0]  dec_read_sum;

  logic [2:0]        row_lo;
  logic [2:0]        row_hi;
  logic [SUM_W-1:0]  draw_sum;
  logic              x_last;
  logic              page_last;

  assign accept = start && !status.busy;

  // Decode the incoming command into a clipped column range and row range.
  always_comb begin
    is_draw = (action == mpfb_pkg::ACT_PIXEL) || (action == mpfb_pkg::ACT_HLINE) ||
              (action == mpfb_pkg::ACT_VLINE) || (action == mpfb_pkg::ACT_RECT);
    case (action)
      mpfb_pkg::ACT_HLINE,
      mpfb_pkg::ACT_RECT:  dec_x_end = (x_end < x_start) ? x_start : x_end;
      default:             dec_x_end = x_start;
    endcase
    case (action)
      mpfb_pkg::ACT_VLINE: dec_y_hi = (y_end < y_start) ? y_start : y_end;
      mpfb_pkg::ACT_RECT:  dec_y_hi = y_end;
      default:             dec_y_hi = y_start;
    endcase
    dec_x_hi    = ({2'b00, dec_x_end} >= WIDTH_9) ? X_LAST : dec_x_end;
    dec_page_hi = ({2'b00, dec_y_hi[5:3]} >= PAGES_5) ? PAGE_LAST : dec_y_hi[5:3];
    dec_empty   = ((action == mpfb_pkg::ACT_RECT) && (y_end < y_start)) ||
                  ({2'b00, x_start} >= WIDTH_9) ||
                  ({2'b00, y_start[5:3]} >= PAGES_5);
    dec_base    = ADDR_W'((PAGE_COUNT - 1 - int'(y_start[5:3])) * WIDTH);
    dec_rd_ok   = (action == mpfb_pkg::ACT_READ) && ({3'b000, read_index} < DEPTH_13);
    dec_read_sum = SUM_W'(read_index);
  end

  // Current draw position and its row mask.
  always_comb begin
    row_lo    = (page_cur == y_lo[5:3]) ? y_lo[2:0] : 3'd0;
    row_hi    = (page_cur == y_hi[5:3]) ? y_hi[2:0] : 3'd7;
    draw_sum  = SUM_W'(base) + SUM_W'(x_cur);
    x_last    = (x_cur == x_hi);
    page_last = (page_cur == page_hi);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mpfb_pkg::ST_INIT: begin
        if (sweep_addr == LAST_ADDR) state_next = mpfb_pkg::ST_IDLE;
      end
      mpfb_pkg::ST_FILL: begin
        if (sweep_addr == LAST_ADDR) state_next = mpfb_pkg::ST_DONE;
      end
      mpfb_pkg::ST_DRAW: begin
        if (x_last && page_last) state_next = mpfb_pkg::ST_DONE;
      end
      mpfb_pkg::ST_READ: begin
        state_next = mpfb_pkg::ST_DONE;
      end
      mpfb_pkg::ST_IDLE,
      mpfb_pkg::ST_DONE: begin
        if (start) begin
          if (is_draw && !dec_empty) begin
            state_next = mpfb_pkg::ST_DRAW;
          end else if (action == mpfb_pkg::ACT_CLEAR) begin
            state_next = mpfb_pkg::ST_FILL;
          end else if (action == mpfb_pkg::ACT_READ) begin
            state_next = mpfb_pkg::ST_READ;
          end else begin
            state_next = mpfb_pkg::ST_DONE;
          end
        end else begin
          state_next = mpfb_pkg::ST_IDLE;
        end
      end
      default: state_next = mpfb_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory request and status.
  always_comb begin
    req          = '0;
    req.op       = mpfb_pkg::MOP_READ;
    req_addr     = read_addr;
    status       = '0;
    status.rd_sel = rd_ok;
    case (state)
      mpfb_pkg::ST_INIT: begin
        req.valid   = 1'b1;
        req.op      = mpfb_pkg::MOP_FILL;
        req.lit     = 1'b0;
        req_addr    = sweep_addr;
        status.busy = 1'b1;
      end
      mpfb_pkg::ST_FILL: begin
        req.valid   = 1'b1;
        req.op      = mpfb_pkg::MOP_FILL;
        req.lit     = lit;
        req_addr    = sweep_addr;
        status.busy = 1'b1;
      end
      mpfb_pkg::ST_DRAW: begin
        req.valid   = 1'b1;
        req.op      = mpfb_pkg::MOP_RMW;
        req.mask    = mpfb_pkg::page_mask(row_lo, row_hi);
        req.lit     = lit;
        req_addr    = draw_sum[ADDR_W-1:0];
        status.busy = 1'b1;
      end
      mpfb_pkg::ST_READ: begin
        req.valid   = rd_ok;
        status.busy = 1'b1;
      end
      mpfb_pkg::ST_DONE: begin
        status.done = 1'b1;
      end
      default: begin
        status.busy = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpfb_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter and read selection; restarted at reset and on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      rd_ok      <= 1'b0;
    end else if (accept) begin
      sweep_addr <= '0;
      rd_ok      <= dec_rd_ok;
    end else if (state == mpfb_pkg::ST_INIT || state == mpfb_pkg::ST_FILL) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // Command registers and the column/page walk of a draw.
  always_ff @(posedge clk) begin
    if (accept) begin
      lit       <= color;
      x_lo      <= x_start;
      x_cur     <= x_start;
      x_hi      <= dec_x_hi;
      y_lo      <= y_start;
      y_hi      <= dec_y_hi;
      page_cur  <= y_start[5:3];
      page_hi   <= dec_page_hi;
      base      <= dec_base;
      read_addr <= dec_read_sum[ADDR_W-1:0];
    end else if (state == mpfb_pkg::ST_DRAW) begin
      if (!x_last) begin
        x_cur <= x_cur + 7'd1;
      end else if (!page_last) begin
        x_cur    <= x_lo;
        page_cur <= page_cur + 3'd1;
        base     <= base - WIDTH_A;
      end
    end
  end

  `MPFB_ASSERT_IMPL(a_no_req_when_idle, clk, rst, (state == mpfb_pkg::ST_IDLE) || (state == mpfb_pkg::ST_DONE), !req.valid)
  `MPFB_ASSERT_IMPL(a_draw_in_range, clk, rst, state == mpfb_pkg::ST_DRAW, (x_cur >= x_lo) && (x_cur <= x_hi) && (page_cur <= page_hi))
  `MPFB_ASSERT_IMPL(a_req_in_store, clk, rst, req.valid, req_addr <= LAST_ADDR)

endmodule

// File: rtl/mono_page_framebuffer_draw.sv
// Page-organized one-bit-per-pixel frame store with pixel, line, rectangle,
// clear and byte-read commands. A command is taken when start is high and
// busy is low; its single result appears for exactly one cycle with done
// high, and read_data holds the byte for an in-range read command and zero
// otherwise. The receiver cannot stall, so done must be sampled when it
// occurs. All work goes through one read-modify-write of the frame memory
// per cycle: a draw updates each byte touched (columns times pages crossed)
// in turn and then gives its result, a read fetches its byte and then gives
// its result, and a clear fills the whole store and then gives its result.
// A new command may be accepted in the cycle done is high. After reset the
// block clears all WIDTH*PAGE_COUNT bytes of the store (1024 at the default
// size) with busy high before it accepts its first command.
module mono_page_framebuffer_draw #(
  parameter int WIDTH      = 128,
  parameter int PAGE_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action,
  input  logic [6:0] x_start,
  input  logic [5:0] y_start,
  input  logic [6:0] x_end,
  input  logic [5:0] y_end,
  input  logic       color,
  input  logic [9:0] read_index,
  output logic       done,
  output logic [7:0] read_data
);

  localparam int DEPTH  = WIDTH * PAGE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  mpfb_pkg::mem_req_t     req;
  logic [ADDR_W-1:0]      req_addr;
  mpfb_pkg::ctrl_status_t status;
  logic [7:0]             mem_rdata;

  // Command sequencer.
  mpfb_ctrl #(
    .WIDTH      (WIDTH),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .color      (color),
    .read_index (read_index),
    .req        (req),
    .req_addr   (req_addr),
    .status     (status)
  );

  // Frame memory with its read-modify-write stage.
  mpfb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .addr  (req_addr),
    .rdata (mem_rdata)
  );

  // Result transaction: the store byte only for an in-range read.
  assign busy      = status.busy;
  assign done      = status.done;
  assign read_data = (status.done && status.rd_sel) ? mem_rdata : 8'h00;

endmodule
